FILE: design/mtfw_pkg.sv
// Shared types and constants of the mutex lock manager.
`default_nettype none

package mtfw_pkg;

   localparam int ID_W     = 6;
   localparam int CMP_W    = ID_W + 1;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 3;
   localparam int RES_W    = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_CREATE = 2'd0,
      MODE_LOCK   = 2'd1,
      MODE_UNLOCK = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED   = 3'd0,
      ST_QUEUED    = 3'd1,
      ST_RELEASED  = 3'd2,
      ST_CREATED   = 3'd3,
      ST_NO_FREE   = 3'd4,
      ST_INVALID   = 3'd5,
      ST_DEADLOCK  = 3'd6,
      ST_NOT_OWNER = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      OP_CREATE,
      OP_LOCK,
      OP_UNLOCK,
      OP_REJECT
   } op_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0]   mutex_id;
      logic [ID_W-1:0]   task_id;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [RES_W-1:0]    result_mutex;
      logic                woken_valid;
      logic [ID_W-1:0]     woken_task;
   } rsp_item_type;

   typedef struct packed {
      op_type          op;
      logic [ID_W-1:0] mutex_id;
      logic [ID_W-1:0] task_id;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type item;
   } work_chan_type;

endpackage

`default_nettype wire

FILE: design/mtfw_if.sv
// Request and response channel interfaces of the mutex lock manager.
`default_nettype none

interface mtfw_req_if import mtfw_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mtfw_rsp_if import mtfw_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/mtfw_front.sv
// Front end: accepts requests and classifies them into operations.
`default_nettype none

module mtfw_front import mtfw_pkg::*; #(
   parameter int NUM_MUTEX,
   parameter int NUM_TASKS
) (
   mtfw_req_if.sink      req,
   input  logic          queue_full,
   output work_chan_type push
);

   logic mutex_ok;
   logic task_ok;

   always_comb begin
      mutex_ok = {1'b0, req.data.mutex_id} < CMP_W'(NUM_MUTEX);
      task_ok  = {1'b0, req.data.task_id} < CMP_W'(NUM_TASKS);
      push.valid         = req.valid && !queue_full;
      push.item.mutex_id = req.data.mutex_id;
      push.item.task_id  = req.data.task_id;
      case (req.data.mode)
         MODE_CREATE: begin
            push.item.op = OP_CREATE;
         end
         MODE_LOCK: begin
            push.item.op = (mutex_ok && task_ok) ? OP_LOCK : OP_REJECT;
         end
         MODE_UNLOCK: begin
            push.item.op = (mutex_ok && task_ok) ? OP_UNLOCK : OP_REJECT;
         end
         default: begin
            push.item.op = OP_REJECT;
         end
      endcase
   end

   assign req.ready = !queue_full;

endmodule

`default_nettype wire

FILE: design/mtfw_queue.sv
// Two-entry queue between the front end and the execution unit.
`default_nettype none

module mtfw_queue import mtfw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  work_chan_type push,
   output logic          full,
   output work_chan_type head,
   input  logic          pop
);

   localparam int DEPTH = 2;
   localparam int PTR_W = 1;
   localparam int CNT_W = 2;

   work_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   always_comb begin
      full       = count_ff == CNT_W'(DEPTH);
      head.valid = count_ff != '0;
      head.item  = entry_ff[rd_ptr_ff];
      do_push    = push.valid && !full;
      do_pop     = pop && head.valid;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         if (do_push) begin
            entry_ff[wr_ptr_ff] <= push.item;
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/mtfw_back.sv
// Execution unit: mutex and waiter tables, lock decisions and the response register.
`default_nettype none

module mtfw_back import mtfw_pkg::*; #(
   parameter int NUM_MUTEX,
   parameter int NUM_TASKS
) (
   input  logic          clock,
   input  logic          reset,
   input  work_chan_type head,
   output logic          pop,
   mtfw_rsp_if.source    rsp
);

   localparam int MW = (NUM_MUTEX > 1) ? $clog2(NUM_MUTEX) : 1;
   localparam int TW = $clog2(NUM_TASKS);
   localparam int CW = $clog2(NUM_MUTEX + 1);

   typedef struct packed {
      logic [TW-1:0] holder;
      logic [TW-1:0] qhead;
      logic [TW-1:0] qtail;
   } mrec_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_WAKE
   } state_type;

   state_type              state_ff;
   state_type              state_in;
   work_type               cur_ff;
   mrec_type               mrd_ff;
   logic [TW-1:0]          link_rd_ff;
   logic [NUM_MUTEX-1:0]   locked_ff;
   logic [NUM_MUTEX-1:0]   locked_in;
   logic [NUM_MUTEX-1:0]   nonempty_ff;
   logic [NUM_MUTEX-1:0]   nonempty_in;
   logic [NUM_TASKS-1:0]   end_ff;
   logic [NUM_TASKS-1:0]   end_in;
   logic [CW-1:0]          alloc_cnt_ff;
   logic [CW-1:0]          alloc_cnt_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_item_type           rsp_data_ff;
   rsp_item_type           rsp_data_in;

   mrec_type               mutex_mem [NUM_MUTEX];
   logic [TW-1:0]          link_mem [NUM_TASKS];

   logic [MW-1:0]          m;
   logic [TW-1:0]          t;
   logic [MW-1:0]          rd_addr;
   logic                   created;
   logic                   is_locked;
   logic                   is_nonempty;
   logic                   out_free;
   logic                   done;
   logic                   mwr_en;
   mrec_type               mwr_data;
   logic                   lwr_en;
   logic                   link_rd_en;
   rsp_item_type           res;

   always_comb begin
      m           = cur_ff.mutex_id[MW-1:0];
      t           = cur_ff.task_id[TW-1:0];
      rd_addr     = head.item.mutex_id[MW-1:0];
      created     = {1'b0, cur_ff.mutex_id} < CMP_W'(alloc_cnt_ff);
      is_locked   = locked_ff[m];
      is_nonempty = nonempty_ff[m];
      out_free    = !rsp_valid_ff || rsp.ready;

      state_in     = state_ff;
      locked_in    = locked_ff;
      nonempty_in  = nonempty_ff;
      end_in       = end_ff;
      alloc_cnt_in = alloc_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      mwr_en       = 1'b0;
      mwr_data     = mrd_ff;
      lwr_en       = 1'b0;
      link_rd_en   = 1'b0;
      done         = 1'b0;

      res.status       = ST_INVALID;
      res.result_mutex = cur_ff.mutex_id[RES_W-1:0];
      res.woken_valid  = 1'b0;
      res.woken_task   = '0;

      case (state_ff)
         S_EXEC: begin
            if (cur_ff.op == OP_UNLOCK && created && is_locked &&
                mrd_ff.holder == t && is_nonempty) begin
               // The oldest waiter's link is read before the hand-over.
               link_rd_en = 1'b1;
               state_in   = S_WAKE;
            end else if (out_free) begin
               done = 1'b1;
               case (cur_ff.op)
                  OP_CREATE: begin
                     if (alloc_cnt_ff < CW'(NUM_MUTEX)) begin
                        res.status       = ST_CREATED;
                        res.result_mutex = RES_W'(alloc_cnt_ff);
                        alloc_cnt_in     = alloc_cnt_ff + 1'b1;
                     end else begin
                        res.status       = ST_NO_FREE;
                        res.result_mutex = '0;
                     end
                  end
                  OP_LOCK: begin
                     if (!created) begin
                        res.status = ST_INVALID;
                     end else if (!is_locked) begin
                        res.status      = ST_GRANTED;
                        locked_in[m]    = 1'b1;
                        mwr_data.holder = t;
                        mwr_en          = 1'b1;
                     end else if (mrd_ff.holder == t) begin
                        res.status = ST_DEADLOCK;
                     end else begin
                        res.status = ST_QUEUED;
                        if (is_nonempty) begin
                           lwr_en               = 1'b1;
                           end_in[mrd_ff.qtail] = 1'b0;
                        end else begin
                           mwr_data.qhead = t;
                           nonempty_in[m] = 1'b1;
                        end
                        end_in[t]      = 1'b1;
                        mwr_data.qtail = t;
                        mwr_en         = 1'b1;
                     end
                  end
                  OP_UNLOCK: begin
                     if (!created) begin
                        res.status = ST_INVALID;
                     end else if (!is_locked || mrd_ff.holder != t) begin
                        res.status = ST_NOT_OWNER;
                     end else begin
                        res.status   = ST_RELEASED;
                        locked_in[m] = 1'b0;
                     end
                  end
                  default: begin
                     res.status = ST_INVALID;
                  end
               endcase
            end
         end
         S_WAKE: begin
            if (out_free) begin
               done            = 1'b1;
               res.status      = ST_RELEASED;
               res.woken_valid = 1'b1;
               res.woken_task  = ID_W'(mrd_ff.qhead);
               mwr_data.holder = mrd_ff.qhead;
               mwr_en          = 1'b1;
               if (end_ff[mrd_ff.qhead]) begin
                  nonempty_in[m] = 1'b0;
               end else begin
                  mwr_data.qhead = link_rd_ff;
               end
            end
         end
         default: begin
         end
      endcase

      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end

      pop = head.valid && (state_ff == S_IDLE || done);
      if (pop) begin
         state_in = S_EXEC;
      end else if (done) begin
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         locked_ff    <= '0;
         nonempty_ff  <= '0;
         alloc_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
         locked_ff    <= locked_in;
         nonempty_ff  <= nonempty_in;
         alloc_cnt_ff <= alloc_cnt_in;
         end_ff       <= end_in;
         if (pop) begin
            cur_ff <= head.item;
         end
      end
   end

   // A record written in the same cycle as the next read is forwarded.
   always_ff @(posedge clock) begin
      if (mwr_en) begin
         mutex_mem[m] <= mwr_data;
      end
      if (pop) begin
         if (mwr_en && m == rd_addr) begin
            mrd_ff <= mwr_data;
         end else begin
            mrd_ff <= mutex_mem[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (lwr_en) begin
         link_mem[mrd_ff.qtail] <= t;
      end
      if (link_rd_en) begin
         link_rd_ff <= link_mem[mrd_ff.qhead];
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_waiters_need_lock: assert property (@(posedge clock) disable iff (reset)
      (nonempty_ff & ~locked_ff) == '0)
      else $error("Mutex has waiters but is not locked.");

   a_lock_only_created: assert property (@(posedge clock) disable iff (reset)
      (locked_ff >> alloc_cnt_ff) == '0)
      else $error("Locked mutex was never created.");

   a_alloc_bound: assert property (@(posedge clock) disable iff (reset)
      alloc_cnt_ff <= CW'(NUM_MUTEX))
      else $error("Creation count exceeds the table size.");

   a_done_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_valid_ff)
      else $error("Finished request left no response.");
`endif

endmodule

`default_nettype wire

FILE: design/mutex_table_fifo_waiters_top.sv
// Top level of the mutex lock manager with FIFO wait queues.
`default_nettype none

// Lock manager for NUM_MUTEX mutexes and NUM_TASKS tasks. Each request
// (create, lock or unlock) gives exactly one response, in order. Requests are
// classified on entry and pass a two-entry queue to the execution unit, which
// reads the mutex record (holder, queue head and tail) from a table memory and
// writes it back when a lock or a hand-over changes it. Back-to-back requests
// run at one per cycle while the response register is free; an unlock that
// hands the mutex to a waiter holds the execution unit longer, because the
// waiter's successor link is then read from the per-task link memory. No
// clearing pass is needed after reset. A waiting task is assumed to be asleep
// and queued only once; priority changes and wake-up are left to the
// surrounding system.
module mutex_table_fifo_waiters_top import mtfw_pkg::*; #(
   parameter int NUM_MUTEX = 32,
   parameter int NUM_TASKS = 64
) (
   input  logic       clock,
   input  logic       reset,
   mtfw_req_if.sink   req_if,
   mtfw_rsp_if.source rsp_if
);

   work_chan_type push;
   work_chan_type head;
   logic          queue_full;
   logic          pop;

   mtfw_front #(
      .NUM_MUTEX (NUM_MUTEX),
      .NUM_TASKS (NUM_TASKS)
   ) u_front (
      .req        (req_if),
      .queue_full (queue_full),
      .push       (push)
   );

   mtfw_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   mtfw_back #(
      .NUM_MUTEX (NUM_MUTEX),
      .NUM_TASKS (NUM_TASKS)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_if)
   );

endmodule

`default_nettype wire
